>>> rtl/core/bounded_deque_defines.svh
// Assertion macros shared by the deque RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bdq_pkg.sv
// Package for the bounded deque: sizes, op and status codes, decision struct, helpers.
// No dependencies.
package bdq_pkg;

  localparam int CAPACITY    = 1024;
  localparam int ITEM_BITS   = 32;
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS    = $clog2(CAPACITY + 1);
  localparam int MODE_BITS   = 3;
  localparam int VALUE_BITS  = 32;
  localparam int POS_BITS    = 10;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 11;
  localparam int SUM_BITS    = ((SLOT_BITS > POS_BITS) ? SLOT_BITS : POS_BITS) + 1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_AT    = 3'd4
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  // Decision for one request, handed from the pointer unit to the top level.
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] addr;
    logic [SLOT_BITS-1:0] front_nxt;
    logic [SLOT_BITS-1:0] back_nxt;
    logic [CNT_BITS-1:0]  cnt_nxt;
    status_t              status;
  } bdq_op_t;

  function automatic logic [SLOT_BITS-1:0] slot_next(input logic [SLOT_BITS-1:0] s);
    if (s == SLOT_BITS'(CAPACITY - 1)) return '0;
    else return s + SLOT_BITS'(1);
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_prev(input logic [SLOT_BITS-1:0] s);
    if (s == '0) return SLOT_BITS'(CAPACITY - 1);
    else return s - SLOT_BITS'(1);
  endfunction

  // Input field to stored item width (zero-extend, then cut).
  function automatic logic [ITEM_BITS-1:0] fit_item(input logic [VALUE_BITS-1:0] v);
    logic [63:0] z;
    z = 64'(v);
    return z[ITEM_BITS-1:0];
  endfunction

  // Stored item to result field: sign-extend from the item width, then cut.
  function automatic logic [VALUE_BITS-1:0] widen_item(input logic [ITEM_BITS-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[VALUE_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/bdq_if.sv
// Request and response channel interfaces for the bounded deque.
// Depends on bdq_pkg.
interface bdq_req_if import bdq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [MODE_BITS-1:0]         mode;
  logic signed [VALUE_BITS-1:0] item_value;
  logic [POS_BITS-1:0]          position;

  modport source (output valid, mode, item_value, position, input ready);
  modport sink   (input valid, mode, item_value, position, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] read_value;
  logic [STATUS_BITS-1:0]       status;
  logic [COUNT_BITS-1:0]        count_after;

  modport source (output valid, read_value, status, count_after, input ready);
  modport sink   (input valid, read_value, status, count_after, output ready);
endinterface

>>> rtl/core/bounded_deque.sv
// Top level of the bounded deque: ring store in RAM, pointer unit, response register.
// Depends on bdq_pkg, bdq_if, bdq_ram, bdq_ptr and bounded_deque_defines.svh.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------
//  in_req   | in  | mode, item_value, position
//  out_rsp  | out | read_value, status, count_after
//
// Pushes and refused requests complete at accept: store write and result at the accept edge.
// Pops and reads pass through FSM_READ: RAM read issued at accept, RAM data registered at the end of FSM_READ.
// One request in flight; the single RAM port, its read latency and back-pressure on out_rsp set the rate.
// Synchronous active-low reset clears pointers, count and handshake state; the
// store itself is not cleared (only written slots are ever read).
// A new beat is taken while the previous result is being drained on out_rsp.
`include "bounded_deque_defines.svh"

module bounded_deque import bdq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  bdq_req_if.sink   in_req,
  bdq_rsp_if.source out_rsp
);

  fsm_t                   state_r;
  fsm_t                   state_nxt;
  bdq_op_t                op;
  logic [CNT_BITS-1:0]    cnt;
  logic                   req_fire;
  logic                   rsp_fire;
  logic                   ram_en;
  logic [ITEM_BITS-1:0]   ram_rdata;
  logic                   load_now;   // result complete at accept
  logic                   load_read;  // RAM data arrives this cycle

  logic                   out_valid_r;
  logic [VALUE_BITS-1:0]  out_value_r;
  status_t                out_status_r;
  logic [COUNT_BITS-1:0]  out_count_r;

  // Accept only when idle and the response register is empty or draining.
  assign in_req.ready = (state_r == FSM_IDLE) && (!out_valid_r || out_rsp.ready);
  assign req_fire     = in_req.valid && in_req.ready;
  assign rsp_fire     = out_valid_r && out_rsp.ready;

  bdq_ptr u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (req_fire),
    .mode     (in_req.mode),
    .position (in_req.position),
    .op       (op),
    .cnt      (cnt)
  );

  // Accesses never overlap: a read is issued no earlier than the cycle after
  // the last write, so the RAM needs no bypass.
  assign ram_en = req_fire && (op.wr_en || op.rd_en);

  bdq_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (op.wr_en),
    .addr  (op.addr),
    .wdata (fit_item(in_req.item_value)),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (req_fire && op.rd_en) state_nxt = FSM_READ;
      FSM_READ: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Load strobes for the response register
  always_comb begin
    load_now  = 1'b0;
    load_read = 1'b0;
    unique case (state_r)
      FSM_IDLE: load_now  = req_fire && !op.rd_en;
      FSM_READ: load_read = 1'b1;
      default: begin
        load_now  = 1'b0;
        load_read = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_now || load_read) begin
        out_valid_r <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: status and count are known at accept; value waits for a read.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      out_status_r <= op.status;
      out_count_r  <= COUNT_BITS'(op.cnt_nxt);
      out_value_r  <= '0;
    end else if (load_read) begin
      out_value_r <= widen_item(ram_rdata);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.count_after = out_count_r;

  `BDQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CNT_BITS'(CAPACITY), "item count above capacity")
  `BDQ_ASSERT_NOW(a_no_accept_in_read, state_r == FSM_READ, !in_req.ready, "accept during read")
  `BDQ_ASSERT_NEXT(a_push_count, req_fire && op.wr_en, cnt == $past(cnt) + CNT_BITS'(1), "push count")
  `BDQ_ASSERT_NEXT(a_quick_rsp, req_fire && !op.rd_en, out_valid_r && state_r == FSM_IDLE, "no result")

endmodule

>>> rtl/core/bdq_ram.sv
// Generic single-port RAM, read-first, registered read data.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/bdq_ptr.sv
// Front/back slot pointers and item count; decides each request's slot and status.
// Depends on bdq_pkg.
module bdq_ptr import bdq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_fire,
  input  logic [MODE_BITS-1:0] mode,
  input  logic [POS_BITS-1:0]  position,
  output bdq_op_t              op,
  output logic [CNT_BITS-1:0]  cnt
);

  logic [SLOT_BITS-1:0] front_r;
  logic [SLOT_BITS-1:0] back_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 full;
  logic                 empty;
  logic [SUM_BITS-1:0]  pos_sum;
  logic [SUM_BITS-1:0]  pos_wrap;

  assign full  = (cnt_r >= CNT_BITS'(CAPACITY));
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

  // position < count <= CAPACITY, so one conditional subtract wraps the sum
  assign pos_sum  = SUM_BITS'(front_r) + SUM_BITS'(position);
  assign pos_wrap = (pos_sum >= SUM_BITS'(CAPACITY)) ? pos_sum - SUM_BITS'(CAPACITY) : pos_sum;

  always_comb begin
    op.wr_en     = 1'b0;
    op.rd_en     = 1'b0;
    op.addr      = front_r;
    op.front_nxt = front_r;
    op.back_nxt  = back_r;
    op.cnt_nxt   = cnt_r;
    op.status    = ST_OK;
    unique case (mode)
      MODE_PUSH_BACK: begin
        if (full) begin
          op.status = ST_FULL;
        end else begin
          op.wr_en    = 1'b1;
          op.addr     = back_r;
          op.back_nxt = slot_next(back_r);
          op.cnt_nxt  = cnt_r + CNT_BITS'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          op.status = ST_FULL;
        end else begin
          op.wr_en     = 1'b1;
          op.addr      = slot_prev(front_r);
          op.front_nxt = slot_prev(front_r);
          op.cnt_nxt   = cnt_r + CNT_BITS'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd_en     = 1'b1;
          op.addr      = front_r;
          op.front_nxt = slot_next(front_r);
          op.cnt_nxt   = cnt_r - CNT_BITS'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd_en    = 1'b1;
          op.addr     = slot_prev(back_r);
          op.back_nxt = slot_prev(back_r);
          op.cnt_nxt  = cnt_r - CNT_BITS'(1);
        end
      end
      MODE_READ_AT: begin
        if (SUM_BITS'(position) >= SUM_BITS'(cnt_r)) begin
          op.status = ST_RANGE;
        end else begin
          op.rd_en = 1'b1;
          op.addr  = pos_wrap[SLOT_BITS-1:0];
        end
      end
      default: begin
        op.status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      cnt_r   <= '0;
    end else if (req_fire) begin
      front_r <= op.front_nxt;
      back_r  <= op.back_nxt;
      cnt_r   <= op.cnt_nxt;
    end
  end

endmodule
